[design/mlr_pkg.sv]
// Shared constants, controller state type and control structs for the line rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package mlr_pkg;

    localparam int MLR_MAX_SPAN   = 63;
    localparam int MLR_COORD_BITS = 11;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_BUSY
    } mlr_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture a new segment from the input beat
        logic step;   // advance to the next pixel
    } mlr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last;   // current pixel closes the segment (or reports an error)
    } mlr_status_t;

endpackage

`default_nettype wire

[design/mlr_ctrl.sv]
// Controller state machine: segment acceptance and pixel beat sequencing.
`timescale 1ns / 1ps
`default_nettype none

module mlr_ctrl
    import mlr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire mlr_status_t status,
    output mlr_cmd_t         cmd
);

    mlr_state_t state_reg;
    mlr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (out_ready && status.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_BUSY:
            begin
                out_valid = 1'b1;
                cmd.step  = out_ready && !status.last;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/mlr_datapath.sv]
// Datapath: octant setup, midpoint decision register, pixel position and step counter.
`timescale 1ns / 1ps
`default_nettype none

module mlr_datapath
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = MLR_COORD_BITS,
    parameter int MAX_SPAN   = MLR_MAX_SPAN
)
(
    input  wire logic                         clk,
    input  wire mlr_cmd_t                     cmd,
    input  wire logic signed [COORD_BITS-1:0] x_start,
    input  wire logic signed [COORD_BITS-1:0] y_start,
    input  wire logic signed [COORD_BITS-1:0] x_end,
    input  wire logic signed [COORD_BITS-1:0] y_end,
    output logic signed [COORD_BITS-1:0]      pixel_x,
    output logic signed [COORD_BITS-1:0]      pixel_y,
    output logic                              last,
    output logic                              span_error,
    output mlr_status_t                       status
);

    localparam int SPAN_W = (MAX_SPAN < 2) ? 1 : $clog2(MAX_SPAN + 1);
    localparam int D_W    = SPAN_W + 3;

    // setup of a new segment
    logic signed [COORD_BITS:0]   dx;
    logic signed [COORD_BITS:0]   dy;
    logic signed [COORD_BITS:0]   dx_abs_full;
    logic signed [COORD_BITS:0]   dy_abs_full;
    logic        [COORD_BITS-1:0] adx;
    logic        [COORD_BITS-1:0] ady;
    logic        [COORD_BITS-1:0] major;
    logic        [COORD_BITS-1:0] minor;
    logic                         shallow;
    logic                         too_long;
    logic        [SPAN_W-1:0]     ma;
    logic        [SPAN_W-1:0]     mb;
    logic signed [D_W-1:0]        two_mb;
    logic signed [D_W-1:0]        two_ma;

    // per-segment registers
    logic signed [COORD_BITS-1:0] px_reg,      px_next;
    logic signed [COORD_BITS-1:0] py_reg,      py_next;
    logic signed [D_W-1:0]        d_reg,       d_next;
    logic signed [D_W-1:0]        inc_e_reg,   inc_e_next;
    logic signed [D_W-1:0]        inc_ne_reg,  inc_ne_next;
    logic        [SPAN_W-1:0]     count_reg,   count_next;
    logic                         shallow_reg, shallow_next;
    logic                         xneg_reg,    xneg_next;
    logic                         yneg_reg,    yneg_next;
    logic                         err_reg,     err_next;

    logic                         diag;
    logic                         move_x;
    logic                         move_y;

    always_comb
    begin
        dx = $signed({x_end[COORD_BITS-1], x_end}) - $signed({x_start[COORD_BITS-1], x_start});
        dy = $signed({y_end[COORD_BITS-1], y_end}) - $signed({y_start[COORD_BITS-1], y_start});
        dx_abs_full = dx[COORD_BITS] ? -dx : dx;
        dy_abs_full = dy[COORD_BITS] ? -dy : dy;
        adx = dx_abs_full[COORD_BITS-1:0];
        ady = dy_abs_full[COORD_BITS-1:0];
        // ties go to the steep octant
        shallow  = adx > ady;
        major    = shallow ? adx : ady;
        minor    = shallow ? ady : adx;
        too_long = 32'(major) > MAX_SPAN;
        ma       = SPAN_W'(major);
        mb       = SPAN_W'(minor);
        two_mb   = $signed({2'b00, mb, 1'b0});
        two_ma   = $signed({2'b00, ma, 1'b0});
    end

    // d >= 0 takes a diagonal step; the major axis always moves
    always_comb
    begin
        diag   = !d_reg[D_W-1];
        move_x = shallow_reg || diag;
        move_y = !shallow_reg || diag;
    end

    always_comb
    begin
        px_next      = px_reg;
        py_next      = py_reg;
        d_next       = d_reg;
        inc_e_next   = inc_e_reg;
        inc_ne_next  = inc_ne_reg;
        count_next   = count_reg;
        shallow_next = shallow_reg;
        xneg_next    = xneg_reg;
        yneg_next    = yneg_reg;
        err_next     = err_reg;
        if (cmd.load)
        begin
            px_next      = too_long ? '0 : x_start;
            py_next      = too_long ? '0 : y_start;
            d_next       = two_mb - $signed({3'b000, ma});
            inc_e_next   = two_mb;
            inc_ne_next  = two_mb - two_ma;
            count_next   = too_long ? '0 : ma;
            shallow_next = shallow;
            xneg_next    = dx[COORD_BITS];
            yneg_next    = dy[COORD_BITS];
            err_next     = too_long;
        end
        else if (cmd.step)
        begin
            if (move_x)
            begin
                px_next = xneg_reg ? px_reg - COORD_BITS'(1) : px_reg + COORD_BITS'(1);
            end
            if (move_y)
            begin
                py_next = yneg_reg ? py_reg - COORD_BITS'(1) : py_reg + COORD_BITS'(1);
            end
            d_next     = d_reg + (diag ? inc_ne_reg : inc_e_reg);
            count_next = count_reg - SPAN_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg      <= px_next;
        py_reg      <= py_next;
        d_reg       <= d_next;
        inc_e_reg   <= inc_e_next;
        inc_ne_reg  <= inc_ne_next;
        count_reg   <= count_next;
        shallow_reg <= shallow_next;
        xneg_reg    <= xneg_next;
        yneg_reg    <= yneg_next;
        err_reg     <= err_next;
    end

    always_comb
    begin
        pixel_x     = px_reg;
        pixel_y     = py_reg;
        last        = err_reg || (count_reg == '0);
        span_error  = err_reg;
        status.last = last;
    end

endmodule

`default_nettype wire

[design/midpoint_line_rasterizer.sv]
// Top level of the eight-octant midpoint line rasterizer.
`timescale 1ns / 1ps
`default_nettype none

// Takes one segment per input beat and emits its pixels, start point first and
// end point last, one output beat per pixel, with last set on the end point.
// The segment's octant only sets which axis is major and the sign of each
// axis step; the midpoint decision value runs in a single register and picks
// between a major-axis step and a diagonal step for every pixel. A segment
// whose major-axis span S is at most MAX_SPAN gives S + 1 beats; a longer one
// gives a single beat at (0, 0) with last and span_error set. Pixels go out
// at one per cycle while out_ready is high. The single decision/position
// register set in the datapath holds one segment at a time, and in_ready is
// high only while no segment is in flight. Coordinates wrap at COORD_BITS
// bits.

module midpoint_line_rasterizer
    import mlr_pkg::*;
#(
    parameter int COORD_BITS = MLR_COORD_BITS,
    parameter int MAX_SPAN   = MLR_MAX_SPAN
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // segment channel
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [COORD_BITS-1:0] x_start,
    input  wire logic signed [COORD_BITS-1:0] y_start,
    input  wire logic signed [COORD_BITS-1:0] x_end,
    input  wire logic signed [COORD_BITS-1:0] y_end,
    // pixel channel
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [COORD_BITS-1:0]      pixel_x,
    output logic signed [COORD_BITS-1:0]      pixel_y,
    output logic                              last,
    output logic                              span_error
);

    mlr_cmd_t    cmd;
    mlr_status_t status;

    // sequencing: take a segment, then hand out one pixel per accepted beat
    mlr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // octant setup, decision value and current pixel; the pixel registers
    // drive the output payload directly and hold while out_ready is low
    mlr_datapath #(
        .COORD_BITS (COORD_BITS),
        .MAX_SPAN   (MAX_SPAN)
    ) u_datapath (
        .clk        (clk),
        .cmd        (cmd),
        .x_start    (x_start),
        .y_start    (y_start),
        .x_end      (x_end),
        .y_end      (y_end),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last       (last),
        .span_error (span_error),
        .status     (status)
    );

endmodule

`default_nettype wire
